// File: design/assert_macros.svh
// Assertion macros used by the RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a property at each rising edge, skipped while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Check a property at each rising edge, reset cycles included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// File: design/ile_pkg.sv
// Types and constants of the indexed list engine.
`default_nettype none

package ile_pkg;

  // Field widths of the stream words
  localparam int FUNC_W   = 2;
  localparam int IDX_W    = 10;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  // Parameter defaults
  localparam int CAPACITY_DEF   = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_GET    = 2'd0,
    FUNC_SET    = 2'd1,
    FUNC_INSERT = 2'd2,
    FUNC_REMOVE = 2'd3
  } func_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

`default_nettype wire

// File: design/indexed_list_engine.sv
// Indexed list engine: a positional list held in one synchronous memory.
//
// Input words (in_*) carry an operation in in_tuser and an index and a value
// in in_tdata: get, set, insert at an index (shifting later elements up) and
// remove at an index (shifting later elements down). Every input word gives
// one result word (out_*) with the read data, the element count after the
// operation and a status in out_tuser (ok, index out of range, store full).
//
// Each word runs through a read state, then a result load; an insert first
// shifts the elements at and above index i up from the top and fills the
// opened slot, and a remove shifts the elements above i down, so both take
// longer the more of the n held elements lie at or above i. Their pace is
// set by the single element memory: one read and one write per cycle, so a
// shift moves one element a cycle through a read-then-write pipeline.
// in_tready is high only while the engine is idle, which includes the time a
// finished result waits in the output register. A stalled receiver holds the
// result there; the next operation then runs and waits before its own load.
// Synchronous reset empties the list (count zero) and drops any result;
// memory contents are not cleared and only data below the count is used.
`default_nettype none
`include "assert_macros.svh"

module indexed_list_engine #(
  parameter int CAPACITY   = ile_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ile_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input word
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [ile_pkg::IN_TDATA_W-1:0] in_tdata,   // index[9:0], value[41:10], zero
  input  wire logic [ile_pkg::FUNC_W-1:0]     in_tuser,   // func[1:0]
  // Result word
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [ile_pkg::OUT_TDATA_W-1:0]     out_tdata,  // read_data[31:0], count[42:32], zero
  output logic [ile_pkg::STATUS_W-1:0]        out_tuser   // status[1:0]
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > ile_pkg::IDX_W) ? CW : ile_pkg::IDX_W;
  localparam int DW = DATA_WIDTH;
  localparam int CX = PW + ile_pkg::COUNT_W;
  localparam int PAD_W = ile_pkg::OUT_TDATA_W - ile_pkg::VAL_W - ile_pkg::COUNT_W;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_READ     = 6'b000010,
    S_SHIFT_UP = 6'b000100,
    S_SHIFT_DN = 6'b001000,
    S_FILL     = 6'b010000,
    S_DONE     = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  ile_pkg::func_t       func_r, func_nxt;
  ile_pkg::status_t     status_r, status_nxt;
  logic [PW-1:0]        idx_r, idx_nxt;
  logic [PW-1:0]        ptr_r, ptr_nxt;
  logic [DW-1:0]        val_r, val_nxt;
  logic [DW-1:0]        rd_r, rd_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ile_pkg::VAL_W-1:0]   out_rd_r, out_rd_nxt;
  ile_pkg::status_t            out_status_r, out_status_nxt;
  logic [ile_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;

  // Element memory ports
  logic [DW-1:0] mem [CAPACITY];
  logic [DW-1:0] mem_rdata_r;
  logic [PW-1:0] raddr;
  logic [PW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic          we;

  // Decoded input word
  logic [PW-1:0]        in_idx;
  logic [PW-1:0]        cnt_ext;
  logic [CX-1:0]        cnt_wide;
  ile_pkg::func_t       in_func;
  logic                 in_acc;
  logic                 out_free;

  assign in_idx   = PW'(in_tdata[ile_pkg::IDX_W-1:0]);
  assign in_func  = ile_pkg::func_t'(in_tuser);
  assign cnt_ext  = PW'(count_r);
  assign cnt_wide = CX'(count_r);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Element memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    mem_rdata_r <= mem[raddr[AW-1:0]];
  end

  // Sequence one operation through read, shift, fill and result load
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    func_nxt       = func_r;
    status_nxt     = status_r;
    idx_nxt        = idx_r;
    ptr_nxt        = ptr_r;
    val_nxt        = val_r;
    rd_nxt         = rd_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_rd_nxt     = out_rd_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    raddr          = in_idx;
    waddr          = idx_r;
    wdata          = val_r;
    we             = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          func_nxt  = in_func;
          idx_nxt   = in_idx;
          val_nxt   = DW'(in_tdata[ile_pkg::IDX_W +: ile_pkg::VAL_W]);
          rd_nxt    = '0;
          state_nxt = S_READ;
          // Check the index against the count, then room for an insert
          if (in_func == ile_pkg::FUNC_INSERT) begin
            if (in_idx > cnt_ext) begin
              status_nxt = ile_pkg::ST_RANGE;
            end else if (cnt_ext == PW'(CAPACITY)) begin
              status_nxt = ile_pkg::ST_FULL;
            end else begin
              status_nxt = ile_pkg::ST_OK;
            end
          end else begin
            status_nxt = (in_idx < cnt_ext) ? ile_pkg::ST_OK : ile_pkg::ST_RANGE;
          end
        end
      end

      S_READ: begin
        state_nxt = S_DONE;
        if (status_r == ile_pkg::ST_OK) begin
          case (func_r)
            ile_pkg::FUNC_GET: begin
              rd_nxt = mem_rdata_r;
            end
            ile_pkg::FUNC_SET: begin
              we = 1'b1;
            end
            ile_pkg::FUNC_INSERT: begin
              if (idx_r == cnt_ext) begin
                state_nxt = S_FILL;
              end else begin
                // Start at the top: move element n-1 to n first
                ptr_nxt   = cnt_ext;
                raddr     = cnt_ext - PW'(1);
                state_nxt = S_SHIFT_UP;
              end
            end
            default: begin
              rd_nxt = mem_rdata_r;
              if (idx_r + PW'(1) == cnt_ext) begin
                count_nxt = count_r - CW'(1);
              end else begin
                // Start at the index: move element i+1 to i first
                ptr_nxt   = idx_r;
                raddr     = idx_r + PW'(1);
                state_nxt = S_SHIFT_DN;
              end
            end
          endcase
        end
      end

      S_SHIFT_UP: begin
        // Write the element read last cycle one place up, fetch the next
        we      = 1'b1;
        waddr   = ptr_r;
        wdata   = mem_rdata_r;
        raddr   = ptr_r - PW'(2);
        ptr_nxt = ptr_r - PW'(1);
        if (ptr_r == idx_r + PW'(1)) begin
          state_nxt = S_FILL;
        end
      end

      S_SHIFT_DN: begin
        // Write the element read last cycle one place down, fetch the next
        we      = 1'b1;
        waddr   = ptr_r;
        wdata   = mem_rdata_r;
        raddr   = ptr_r + PW'(2);
        ptr_nxt = ptr_r + PW'(1);
        if (ptr_r + PW'(2) == cnt_ext) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_FILL: begin
        // Place the inserted value at the opened slot
        we        = 1'b1;
        count_nxt = count_r + CW'(1);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        // Load the result once the output register is free
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_rd_nxt     = ile_pkg::VAL_W'(rd_r);
          out_status_nxt = status_r;
          out_count_nxt  = cnt_wide[ile_pkg::COUNT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Operation and result payload
  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    status_r     <= status_nxt;
    idx_r        <= idx_nxt;
    ptr_r        <= ptr_nxt;
    val_r        <= val_nxt;
    rd_r         <= rd_nxt;
    out_rd_r     <= out_rd_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_count_r, out_rd_r};
  assign out_tuser  = out_status_r;

  // Checks
  `ASSERT_CLK(a_count_bound, clk, rst_n, count_r <= CW'(CAPACITY))
  `ASSERT_CLK(a_accept_reads, clk, rst_n, in_acc |=> state_r == S_READ)
  `ASSERT_CLK(a_fill_grows, clk, rst_n, state_r == S_FILL |=> count_r == $past(count_r) + CW'(1))
  `ASSERT_CLK(a_shift_above, clk, rst_n, state_r == S_SHIFT_UP |-> ptr_r > idx_r)
  `ASSERT_CLK(a_load_from_done, clk, rst_n, $rose(out_tvalid) |-> $past(state_r == S_DONE))
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid)

endmodule

`default_nettype wire
